// ===== hw/rtl/lef_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and the clamp function for the laplacian edge filter
// no dependencies

package lef_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int PIX_W      = 8;
   localparam int WIDTH_W    = 11;
   localparam int ROW_W      = 16;
   localparam int SUM_W      = PIX_W + 2;
   localparam int WCMP_W     = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET  = WIDTH_W'(1024);
   localparam logic [ROW_W-1:0]   HEIGHT_RESET = ROW_W'(1);
   localparam logic [PIX_W-1:0]   PIX_MAX      = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // 4*centre - sum, clamped to the pixel range
   function automatic logic [PIX_W-1:0] clamp_lap(input logic [PIX_W-1:0] centre,
                                                  input logic [SUM_W-1:0] sum);
      logic [SUM_W:0] diff;
      diff = {1'b0, centre, 2'b00} - {1'b0, sum};
      if (diff[SUM_W]) begin
         return '0;
      end else if (diff[SUM_W-1:PIX_W] != '0) begin
         return PIX_MAX;
      end else begin
         return diff[PIX_W-1:0];
      end
   endfunction

endpackage

// ===== hw/rtl/lef_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// read during write to the same address returns the old contents; no dependencies

module lef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/laplacian_edge_filter.sv =====
`timescale 1ns / 1ps
// top level of the 4-neighbour laplacian edge filter
// uses lef_pkg and two lef_ram line banks (even rows, odd rows)
//
//   channel | ports                                 | direction
//   req     | req_valid, req_stall, req_pixel_value | pixel in, raster order
//   rsp     | rsp_valid, rsp_stall, rsp_edge_value, | result out, one row behind
//           | rsp_frame_end                         |
//   csr     | csr_write_en, csr_index, csr_write_data | width / height writes
//
// one pixel transfer per cycle unless stalled; each bank is read once and written at most
// once per pixel, reading one column ahead so the window is complete when the pixel
// reaches stage 1. a pixel's first result passes the stage 1, buffer and output registers;
// last-row pixels give up to three results, one per cycle unless stalled; input waits.
// synchronous reset clears control state only; the line banks need no clearing pass.
// a stall on rsp backs up through the result buffer and stage 1 into req_stall.

module laplacian_edge_filter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lef_pkg::PIX_W-1:0]      req_pixel_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lef_pkg::PIX_W-1:0]      rsp_edge_value,
   output logic                           rsp_frame_end,
   input  logic                           csr_write_en,
   input  logic [lef_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lef_pkg::CSR_DATA_W-1:0] csr_write_data
);

   typedef struct packed {
      logic [lef_pkg::PIX_W-1:0] pixel;
      logic                      x_gt0;
      logic                      x_gt1;
      logic                      has_right;
      logic                      y_gt0;
      logic                      y_gt1;
      logic                      last_row;
      logic                      last_col;
      logic                      up1_sel;   // bank holding the row above the next pixel
      logic                      fwd;       // one-pixel rows: lookahead hits the write
   } s1_type;

   // configuration and position
   logic [lef_pkg::WIDTH_W-1:0] width_ff, width_in;
   logic [lef_pkg::ROW_W-1:0]   height_ff, height_in;
   logic [lef_pkg::COL_W-1:0]   col_ff, col_in;
   logic [lef_pkg::ROW_W-1:0]   row_ff, row_in;

   logic [lef_pkg::WCMP_W-1:0]  width_ext;
   logic [lef_pkg::COL_W-1:0]   col_last;
   logic [lef_pkg::ROW_W-1:0]   row_last;
   logic                        accept;
   logic                        last_col;
   logic                        last_row;
   logic                        y0;
   logic [lef_pkg::COL_W-1:0]   rd_addr;

   // line banks
   logic [lef_pkg::PIX_W-1:0]   bank0_rd, bank1_rd;

   // stage 1 and window
   logic                        s1_valid_ff, s1_valid_in;
   s1_type                      s1_ff, s1_in;
   logic [lef_pkg::PIX_W-1:0]   up1_prev_ff, up1_cur_ff, up2_cur_ff;
   logic [lef_pkg::PIX_W-1:0]   cur_prev1_ff, cur_prev2_ff;
   logic [lef_pkg::PIX_W-1:0]   up1_rd, up2_rd, up1_nxt;
   logic [lef_pkg::SUM_W-1:0]   sum_a, sum_b, sum_c;
   logic [lef_pkg::PIX_W-1:0]   res_a, res_b, res_c;
   logic                        s1_adv;

   // result buffer and output register
   logic [2:0]                  bnd_mask_ff, bnd_mask_in;
   logic [lef_pkg::PIX_W-1:0]   bnd_a_ff, bnd_b_ff, bnd_c_ff;
   logic [2:0]                  pick;
   logic [2:0]                  pending;
   logic                        out_load;
   logic                        s2_ready;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lef_pkg::PIX_W-1:0]   rsp_edge_ff, rsp_edge_in;
   logic                        rsp_end_ff, rsp_end_in;

   // effective geometry
   always_comb begin
      width_ext = lef_pkg::WCMP_W'(width_ff);
      if (width_ext >= lef_pkg::WCMP_W'(lef_pkg::MAX_WIDTH)) begin
         col_last = lef_pkg::COL_W'(lef_pkg::MAX_WIDTH - 1);
      end else if (width_ext == '0) begin
         col_last = '0;
      end else begin
         col_last = lef_pkg::COL_W'(width_ext - 1'b1);
      end
      row_last = (height_ff == '0) ? '0 : height_ff - 1'b1;
   end

   assign accept   = req_valid && !req_stall;
   assign last_col = (col_ff >= col_last);
   assign last_row = (row_ff >= row_last);
   assign y0       = row_ff[0];
   assign rd_addr  = last_col ? '0 : col_ff + 1'b1;

   // configuration and counters
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_write_en) begin
         case (lef_pkg::csr_index_type'(csr_index))
            lef_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_write_data[lef_pkg::WIDTH_W-1:0];
            end
            lef_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_write_data[lef_pkg::ROW_W-1:0];
            end
            default: begin
            end
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lef_pkg::WIDTH_RESET;
         height_ff <= lef_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // both banks read the same lookahead column; the current pixel goes to its row's bank
   lef_ram #(
      .WIDTH (lef_pkg::PIX_W),
      .DEPTH (lef_pkg::MAX_WIDTH)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (accept && !y0),
      .wr_addr (col_ff),
      .wr_data (req_pixel_value),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (bank0_rd)
   );

   lef_ram #(
      .WIDTH (lef_pkg::PIX_W),
      .DEPTH (lef_pkg::MAX_WIDTH)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (accept && y0),
      .wr_addr (col_ff),
      .wr_data (req_pixel_value),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (bank1_rd)
   );

   // stage 1 capture
   always_comb begin
      s1_in.pixel     = req_pixel_value;
      s1_in.x_gt0     = (col_ff != '0);
      s1_in.x_gt1     = (col_ff > lef_pkg::COL_W'(1));
      s1_in.has_right = !last_col;
      s1_in.y_gt0     = (row_ff != '0);
      s1_in.y_gt1     = (row_ff > lef_pkg::ROW_W'(1));
      s1_in.last_row  = last_row;
      s1_in.last_col  = last_col;
      s1_in.up1_sel   = last_col ? y0 : !y0;
      s1_in.fwd       = last_col && (col_ff == '0);
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // stage 1 arithmetic
   always_comb begin
      up1_rd  = s1_ff.up1_sel ? bank1_rd : bank0_rd;
      up2_rd  = s1_ff.up1_sel ? bank0_rd : bank1_rd;
      up1_nxt = s1_ff.fwd ? s1_ff.pixel : up1_rd;

      sum_a = lef_pkg::SUM_W'(s1_ff.pixel)
            + (s1_ff.y_gt1     ? lef_pkg::SUM_W'(up2_cur_ff)  : '0)
            + (s1_ff.x_gt0     ? lef_pkg::SUM_W'(up1_prev_ff) : '0)
            + (s1_ff.has_right ? lef_pkg::SUM_W'(up1_nxt)     : '0);
      sum_b = lef_pkg::SUM_W'(s1_ff.pixel)
            + (s1_ff.y_gt0 ? lef_pkg::SUM_W'(up1_prev_ff)  : '0)
            + (s1_ff.x_gt1 ? lef_pkg::SUM_W'(cur_prev2_ff) : '0);
      sum_c = (s1_ff.y_gt0 ? lef_pkg::SUM_W'(up1_cur_ff)   : '0)
            + (s1_ff.x_gt0 ? lef_pkg::SUM_W'(cur_prev1_ff) : '0);

      res_a = lef_pkg::clamp_lap(up1_cur_ff, sum_a);
      res_b = lef_pkg::clamp_lap(cur_prev1_ff, sum_b);
      res_c = lef_pkg::clamp_lap(s1_ff.pixel, sum_c);
   end

   // window slides one column per pixel that leaves stage 1
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         up1_prev_ff  <= up1_cur_ff;
         up1_cur_ff   <= up1_nxt;
         up2_cur_ff   <= up2_rd;
         cur_prev2_ff <= cur_prev1_ff;
         cur_prev1_ff <= s1_ff.pixel;
      end
   end

   // result buffer: oldest pending result first
   always_comb begin
      out_load = !rsp_valid_ff || !rsp_stall;
      pick     = bnd_mask_ff & (~bnd_mask_ff + 3'd1);
      pending  = out_load ? (bnd_mask_ff & ~pick) : bnd_mask_ff;
      s2_ready = (pending == '0);
      s1_adv   = s1_valid_ff && s2_ready;

      if (s1_adv) begin
         bnd_mask_in = {s1_ff.last_row && s1_ff.last_col,
                        s1_ff.last_row && s1_ff.x_gt0,
                        s1_ff.y_gt0};
      end else begin
         bnd_mask_in = pending;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_edge_in  = rsp_edge_ff;
      rsp_end_in   = rsp_end_ff;
      if (out_load) begin
         rsp_valid_in = (bnd_mask_ff != '0);
         if (pick[0]) begin
            rsp_edge_in = bnd_a_ff;
            rsp_end_in  = 1'b0;
         end else if (pick[1]) begin
            rsp_edge_in = bnd_b_ff;
            rsp_end_in  = 1'b0;
         end else begin
            rsp_edge_in = bnd_c_ff;
            rsp_end_in  = 1'b1;
         end
      end
   end

   assign req_stall = s1_valid_ff && !s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bnd_mask_ff  <= bnd_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         bnd_a_ff <= res_a;
         bnd_b_ff <= res_b;
         bnd_c_ff <= res_c;
      end
      rsp_edge_ff <= rsp_edge_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = rsp_edge_ff;
   assign rsp_frame_end  = rsp_end_ff;

endmodule

// ===== hw/rtl/lef_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the laplacian edge filter, bound to the top level
// uses lef_pkg and laplacian_edge_filter

module lef_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [lef_pkg::PIX_W-1:0] rsp_edge_value,
   input logic                      rsp_frame_end
);

   // an empty pipe takes the next pixel at once
   a_reset_no_stall : assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("req_stall high right after reset");

   // after reset, a result must first pass capture, stage 1 and the buffer
   a_reset_latency : assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result appeared before the pipeline could fill");

   // a stalled result keeps its value and its frame mark
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_edge_value)
                                 && $stable(rsp_frame_end))
      else $error("stalled result changed");

endmodule

bind laplacian_edge_filter lef_checker u_lef_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_edge_value (rsp_edge_value),
   .rsp_frame_end  (rsp_frame_end)
);
